### rtl/core/i2c_master_byte_controller_assert.svh
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BYTE_CONTROLLER_ASSERT_SVH
`define I2C_MASTER_BYTE_CONTROLLER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define I2C_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define I2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_START   = 3'd1,
    KIND_RESTART = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_WRITE   = 3'd4,
    KIND_READ    = 3'd5,
    KIND_ACK     = 3'd6,
    KIND_NONE    = 3'd7
  } kind_t;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_BAUD   = 1'b1;

  localparam logic [3:0] WRITE_LAST_BIT = 4'd8;
  localparam logic [3:0] READ_LAST_BIT  = 4'd7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = 1;

  // Classified beat passed from the front to the back part.
  typedef struct packed {
    logic       is_cmd;
    kind_t      kind;
    logic [7:0] data_byte;
    logic       ack_value;
    logic       sda_in;
    logic       scl_in;
  } op_t;

  // Result beat.
  typedef struct packed {
    logic       collision;
    logic       busy_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       done_res;
    logic       sda_low;
    logic       scl_low;
  } res_t;

endpackage

### rtl/core/i2cm_front.sv
// Input decode and a two-entry queue toward the bus engine.
module i2cm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_kind,
  input  logic [10:0]      in_data,
  output logic             op_valid,
  input  logic             op_ready,
  output i2cm_pkg::op_t    op
);

  i2cm_pkg::op_t q_mem [i2cm_pkg::QUEUE_DEPTH];
  logic [i2cm_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [i2cm_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [i2cm_pkg::QUEUE_AW:0]   count;
  i2cm_pkg::op_t cls;
  logic push;
  logic pop;

  // Classify the beat: kinds start through send ack are commands.
  always_comb begin
    cls.kind      = i2cm_pkg::kind_t'(in_kind);
    cls.data_byte = in_data[7:0];
    cls.ack_value = in_data[8];
    cls.sda_in    = in_data[9];
    cls.scl_in    = in_data[10];
    cls.is_cmd    = (cls.kind != i2cm_pkg::KIND_TICK) && (cls.kind != i2cm_pkg::KIND_NONE);
  end

  assign in_ready = (count != (i2cm_pkg::QUEUE_AW+1)'(i2cm_pkg::QUEUE_DEPTH));
  assign op_valid = (count != '0);
  assign op       = q_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (i2cm_pkg::QUEUE_AW+1)'(push) - (i2cm_pkg::QUEUE_AW+1)'(pop);
    end
  end

endmodule

### rtl/core/i2cm_back.sv
// Bus sequencer: runs one queued beat per cycle into an output register unless the result stalls.
module i2cm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          op_valid,
  output logic          op_ready,
  input  i2cm_pkg::op_t op,
  output logic          res_valid,
  input  logic          res_ready,
  output i2cm_pkg::res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_RESTART = 3'd2,
    PH_STOP    = 3'd3,
    PH_WRITE   = 3'd4,
    PH_READ    = 3'd5,
    PH_ACK     = 3'd6
  } phase_t;

  logic       enable;
  logic [7:0] baud_divider;
  phase_t     phase, phase_next;
  logic       half_bit, half_bit_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] baud_count, baud_count_next;
  logic       ack_status, ack_status_next;
  logic [7:0] receive_buffer, receive_buffer_next;
  logic       ack_to_send, ack_to_send_next;
  logic       hold_scl, hold_scl_next;
  logic       hold_sda, hold_sda_next;
  logic       done, coll;
  logic       cur_scl, new_scl, new_sda;
  logic       step;

  assign op_ready = !res_valid || res_ready;
  assign step = op_valid && op_ready;

  // Line drives for a given phase and position.
  function automatic logic [1:0] drive_of(phase_t p, logic hb, logic [3:0] bc,
                                          logic [7:0] sr, logic ats, logic hs, logic hd);
    logic c;
    logic d;
    begin
      c = 1'b0;
      d = 1'b0;
      unique case (p)
        PH_IDLE:    begin c = hs; d = hd; end
        PH_START:   begin c = 1'b0; d = (bc >= 4'd1); end
        PH_RESTART: begin c = (bc == 4'd0); d = (bc >= 4'd2); end
        PH_STOP:    begin c = (bc == 4'd0); d = (bc <= 4'd1); end
        PH_WRITE: begin
          c = !hb;
          d = (bc < 4'd8) ? !sr[3'd7 - bc[2:0]] : 1'b0;
        end
        PH_READ:    begin c = !hb; d = 1'b0; end
        PH_ACK:     begin c = !hb; d = !ats; end
        default:    begin c = 1'b0; d = 1'b0; end
      endcase
      drive_of = {c, d};
    end
  endfunction

  // SCL drive alone, used to detect a stretched clock.
  function automatic logic scl_of(phase_t p, logic hb, logic [3:0] bc, logic hs);
    logic c;
    begin
      unique case (p)
        PH_IDLE:                   c = hs;
        PH_START:                  c = 1'b0;
        PH_RESTART, PH_STOP:       c = (bc == 4'd0);
        PH_WRITE, PH_READ, PH_ACK: c = !hb;
        default:                   c = 1'b0;
      endcase
      scl_of = c;
    end
  endfunction

  assign cur_scl = scl_of(phase, half_bit, bit_count, hold_scl);
  assign {new_scl, new_sda} = drive_of(phase_next, half_bit_next, bit_count_next,
                                       shift_reg_next, ack_to_send_next, hold_scl_next,
                                       hold_sda_next);

  // Next state for one beat.
  always_comb begin
    phase_next = phase;
    half_bit_next = half_bit;
    bit_count_next = bit_count;
    shift_reg_next = shift_reg;
    baud_count_next = baud_count;
    ack_status_next = ack_status;
    receive_buffer_next = receive_buffer;
    ack_to_send_next = ack_to_send;
    hold_scl_next = hold_scl;
    hold_sda_next = hold_sda;
    done = 1'b0;
    coll = 1'b0;
    if (!enable) begin
      phase_next = PH_IDLE;
      half_bit_next = 1'b0;
      bit_count_next = '0;
      baud_count_next = '0;
      hold_scl_next = 1'b0;
      hold_sda_next = 1'b0;
    end else if (op.is_cmd) begin
      if (phase != PH_IDLE) begin
        coll = 1'b1;
      end else begin
        phase_next = phase_t'(op.kind);
        half_bit_next = 1'b0;
        bit_count_next = '0;
        baud_count_next = '0;
        if (op.kind == i2cm_pkg::KIND_WRITE) shift_reg_next = op.data_byte;
        if (op.kind == i2cm_pkg::KIND_ACK) ack_to_send_next = op.ack_value;
      end
    end else if (phase != PH_IDLE) begin
      if (!cur_scl && !op.scl_in) begin
        // Slave stretches the clock: hold.
      end else if (baud_count >= baud_divider) begin
        baud_count_next = '0;
        unique case (phase)
          PH_START, PH_RESTART, PH_STOP: begin
            if ((phase == PH_START && bit_count >= 4'd1) ||
                (phase != PH_START && bit_count >= 4'd2)) begin
              done = 1'b1;
              phase_next = PH_IDLE;
              bit_count_next = '0;
              half_bit_next = 1'b0;
              hold_scl_next = 1'b0;
              hold_sda_next = (phase != PH_STOP);
            end else begin
              bit_count_next = bit_count + 4'd1;
            end
          end
          PH_WRITE, PH_READ, PH_ACK: begin
            if (!half_bit) begin
              half_bit_next = 1'b1;
            end else begin
              if (phase == PH_READ) shift_reg_next = {shift_reg[6:0], op.sda_in};
              if ((phase == PH_WRITE && bit_count >= i2cm_pkg::WRITE_LAST_BIT) ||
                  (phase == PH_READ && bit_count >= i2cm_pkg::READ_LAST_BIT) ||
                  (phase == PH_ACK)) begin
                done = 1'b1;
                if (phase == PH_WRITE) ack_status_next = op.sda_in;
                if (phase == PH_READ) receive_buffer_next = {shift_reg[6:0], op.sda_in};
                phase_next = PH_IDLE;
                half_bit_next = 1'b0;
                bit_count_next = '0;
                hold_scl_next = 1'b1;
                hold_sda_next = 1'b0;
              end else begin
                half_bit_next = 1'b0;
                bit_count_next = bit_count + 4'd1;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end else begin
        baud_count_next = baud_count + 8'd1;
      end
    end
  end

  // State, configuration and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      baud_divider <= '0;
      phase <= PH_IDLE;
      half_bit <= 1'b0;
      bit_count <= '0;
      shift_reg <= '0;
      baud_count <= '0;
      ack_status <= 1'b0;
      receive_buffer <= '0;
      ack_to_send <= 1'b0;
      hold_scl <= 1'b0;
      hold_sda <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == i2cm_pkg::CFG_ENABLE) enable <= cfg_data[0];
        else baud_divider <= cfg_data;
      end
      if (step) begin
        phase <= phase_next;
        half_bit <= half_bit_next;
        bit_count <= bit_count_next;
        shift_reg <= shift_reg_next;
        baud_count <= baud_count_next;
        ack_status <= ack_status_next;
        receive_buffer <= receive_buffer_next;
        ack_to_send <= ack_to_send_next;
        hold_scl <= hold_scl_next;
        hold_sda <= hold_sda_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.scl_low <= new_scl;
      res.sda_low <= new_sda;
      res.done_res <= done;
      res.ack_received <= ack_status_next;
      res.read_data <= receive_buffer_next;
      res.busy_res <= (phase_next != PH_IDLE);
      res.collision <= coll;
    end
  end

endmodule

### rtl/core/i2c_master_byte_controller.sv
// Byte-level I2C master. Each input beat is a tick or a command (start, repeated
// start, stop, write byte, receive byte, send ack) and yields exactly one result
// beat carrying the SCL/SDA pull-low drives, done, the received ACK, the last read
// byte, busy and collision. A beat is taken every clock while the two-entry input
// queue has room; it passes through the queue, then the sequencer's output register.
// Each half bit lasts baud_divider+1 ticks; ticks hold while a slave stretches SCL.
module i2c_master_byte_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], ack_value[8], sda_in[9],
                                     // scl_in[10], zero[15:11]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // scl_low[0], sda_low[1], done_res[2],
                                     // ack_received[3], read_data[11:4], busy_res[12],
                                     // collision[13], zero[15:14]
);

  logic           op_valid;
  logic           op_ready;
  i2cm_pkg::op_t  op;
  i2cm_pkg::res_t res;

  i2cm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_data  (s_axis_tdata[10:0]),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

### rtl/core/i2cm_checker.sv
`include "i2c_master_byte_controller_assert.svh"

// Port-level checks on the result stream.
module i2cm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  `I2C_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "beat moved")
  `I2C_ASSERT_IMPL(a_done, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[12], "done busy")
  `I2C_ASSERT_IMPL(a_coll, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[12], "stray coll")
  `I2C_ASSERT_IMPL(a_pad, 1'b1, m_axis_tdata[15:14] == 2'b00, "pad bits set")

endmodule

bind i2c_master_byte_controller i2cm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
